FILE: rtl/servo_slew_position_controller_defines.svh
// assertion macros for the servo slew position controller checker
`ifndef SERVO_SLEW_POSITION_CONTROLLER_DEFINES_SVH
`define SERVO_SLEW_POSITION_CONTROLLER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property that also looks at the reset cycles
`define SSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/ssp_pkg.sv
// shared types and constants of the servo slew position controller
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int unsigned ANGLE_W      = 9;
  localparam int unsigned IN_ANGLE_W   = 11;
  localparam int unsigned PWM_W        = 16;
  localparam int unsigned DIV_W        = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned IN_TUSER_W   = 2;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned PROD_W       = ANGLE_W + PWM_W;
  localparam int unsigned QUOT_W       = PWM_W + 2;

  localparam int unsigned TICKS_PER_STEP_DEF = 10;

  // x / 45 as (x * DIV45_MULT) >> DIV45_SHIFT, exact for x below 2**23
  localparam int unsigned DIV45_SHIFT = 29;
  localparam int unsigned DIV45_IN_W  = 23;
  localparam int unsigned DIV45_M_W   = 24;
  localparam logic [DIV45_M_W-1:0] DIV45_MULT =
    DIV45_M_W'((64'd1 << DIV45_SHIFT) / 45 + 1);

  localparam logic [ANGLE_W-1:0] HALF_TURN_DEG = 9'd180;
  localparam logic [ANGLE_W-1:0] FULL_TURN_DEG = 9'd360;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DIRECT = 2'd1,
    OP_GOAL   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_LOW       = 3'd0,
    REG_PWM_HIGH      = 3'd1,
    REG_ANGLE_FLOOR   = 3'd2,
    REG_ANGLE_CEILING = 3'd3,
    REG_FULL_TURN     = 3'd4,
    REG_STEP_SIZE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm_low;
    logic [PWM_W-1:0]   pwm_high;
    logic [ANGLE_W-1:0] angle_floor;
    logic [ANGLE_W-1:0] angle_ceiling;
    logic               full_turn;
    logic [ANGLE_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] pos;
    logic [ANGLE_W-1:0] goal;
    logic               step;
  } servo_st_t;

  typedef struct packed {
    logic ld_snap;
    logic ld_prod;
    logic ld_quot;
    logic ld_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/ssp_state.sv
// servo state update: clamping, direct and goal commands, slew stepping
`timescale 1ns / 1ps
`default_nettype none

module ssp_state #(
  parameter int unsigned TICKS_PER_STEP = ssp_pkg::TICKS_PER_STEP_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  upd,
  input  wire ssp_pkg::op_t                          op,
  input  wire logic signed [ssp_pkg::IN_ANGLE_W-1:0] angle,
  input  wire ssp_pkg::cfg_t                         cfg,
  output ssp_pkg::servo_st_t                         st_nxt
);

  localparam logic [ssp_pkg::DIV_W-1:0] TPS = ssp_pkg::DIV_W'(TICKS_PER_STEP);

  ssp_pkg::servo_st_t            st_r;
  logic [ssp_pkg::DIV_W-1:0]     div_r;
  logic [ssp_pkg::DIV_W-1:0]     div_nxt;
  logic [ssp_pkg::DIV_W-1:0]     div_inc;
  logic signed [11:0]            req;
  logic signed [11:0]            up;
  logic signed [11:0]            down;
  logic signed [10:0]            delta;
  logic [9:0]                    mag;

  // floor, then ceiling, then the servo's own range
  function automatic logic [ssp_pkg::ANGLE_W-1:0] clamp_angle(
    input logic signed [11:0] a,
    input ssp_pkg::cfg_t      c
  );
    logic signed [11:0] v;
    logic signed [11:0] top;
    v   = a;
    top = c.full_turn ? $signed({3'b0, ssp_pkg::FULL_TURN_DEG})
                      : $signed({3'b0, ssp_pkg::HALF_TURN_DEG});
    if (v < $signed({3'b0, c.angle_floor}))   v = $signed({3'b0, c.angle_floor});
    if (v > $signed({3'b0, c.angle_ceiling})) v = $signed({3'b0, c.angle_ceiling});
    if (v < 12'sd0) v = 12'sd0;
    if (v > top)    v = top;
    return v[ssp_pkg::ANGLE_W-1:0];
  endfunction

  always_comb begin
    req     = $signed({angle[ssp_pkg::IN_ANGLE_W-1], angle});
    up      = $signed({3'b0, st_r.pos}) + $signed({3'b0, cfg.step_size});
    down    = $signed({3'b0, st_r.pos}) - $signed({3'b0, cfg.step_size});
    delta   = $signed({2'b0, st_r.goal}) - $signed({2'b0, st_r.pos});
    mag     = delta[10] ? 10'(-delta) : delta[9:0];
    div_inc = div_r + 1'b1;
    st_nxt  = st_r;
    div_nxt = div_r;
    if (upd) begin
      case (op)
        ssp_pkg::OP_TICK: begin
          if (st_r.step) begin
            if (st_r.pos == st_r.goal) begin
              st_nxt.step = 1'b0;
            end else if (div_inc >= TPS) begin
              div_nxt = '0;
              if (mag <= {1'b0, cfg.step_size}) begin
                st_nxt.pos  = clamp_angle($signed({3'b0, st_r.goal}), cfg);
                st_nxt.step = 1'b0;
              end else if (!delta[10]) begin
                st_nxt.pos = clamp_angle(up, cfg);
              end else begin
                st_nxt.pos = clamp_angle(down, cfg);
              end
            end else begin
              div_nxt = div_inc;
            end
          end
        end
        ssp_pkg::OP_DIRECT: begin
          st_nxt.pos  = clamp_angle(req, cfg);
          st_nxt.goal = clamp_angle(req, cfg);
          st_nxt.step = 1'b0;
        end
        ssp_pkg::OP_GOAL: begin
          st_nxt.goal = clamp_angle(req, cfg);
          st_nxt.step = 1'b1;
        end
        default: begin
          // unused op code leaves the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      div_r <= '0;
    end else begin
      st_r  <= st_nxt;
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssp_pwm.sv
// pwm compare pipeline: snapshot, angle times span, divide by range, offset
`timescale 1ns / 1ps
`default_nettype none

module ssp_pwm (
  input  wire logic                          clk,
  input  wire ssp_pkg::pipe_ctl_t            ctl,
  input  wire ssp_pkg::servo_st_t            st_nxt,
  input  wire ssp_pkg::cfg_t                 cfg,
  output logic [ssp_pkg::PWM_W-1:0]          pwm_compare,
  output ssp_pkg::servo_st_t                 st_out
);

  ssp_pkg::servo_st_t                 snap_r;
  ssp_pkg::servo_st_t                 prod_st_r;
  ssp_pkg::servo_st_t                 quot_st_r;
  ssp_pkg::servo_st_t                 out_st_r;
  logic [ssp_pkg::PWM_W-1:0]          span;
  logic [ssp_pkg::PROD_W-1:0]         prod_nxt;
  logic [ssp_pkg::PROD_W-1:0]         prod_r;
  logic [ssp_pkg::DIV45_IN_W-1:0]     scaled;
  logic [ssp_pkg::DIV45_IN_W+ssp_pkg::DIV45_M_W-1:0] recip;
  logic [ssp_pkg::QUOT_W-1:0]         quot_r;
  logic [ssp_pkg::PWM_W-1:0]          pwm_nxt;
  logic [ssp_pkg::PWM_W-1:0]          pwm_r;

  always_comb begin
    // reversed bounds give a zero span
    span     = (cfg.pwm_high >= cfg.pwm_low) ? (cfg.pwm_high - cfg.pwm_low) : '0;
    prod_nxt = ssp_pkg::PROD_W'(snap_r.pos) * ssp_pkg::PROD_W'(span);
    // /180 = /4 then /45, /360 = /8 then /45
    scaled   = cfg.full_turn ? ssp_pkg::DIV45_IN_W'(prod_r >> 3)
                             : ssp_pkg::DIV45_IN_W'(prod_r >> 2);
    recip    = (ssp_pkg::DIV45_IN_W + ssp_pkg::DIV45_M_W)'(scaled) *
               (ssp_pkg::DIV45_IN_W + ssp_pkg::DIV45_M_W)'(ssp_pkg::DIV45_MULT);
    pwm_nxt  = cfg.pwm_low + quot_r[ssp_pkg::PWM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_snap) begin
      snap_r <= st_nxt;
    end
    if (ctl.ld_prod) begin
      prod_r    <= prod_nxt;
      prod_st_r <= snap_r;
    end
    if (ctl.ld_quot) begin
      quot_r    <= recip[ssp_pkg::DIV45_SHIFT +: ssp_pkg::QUOT_W];
      quot_st_r <= prod_st_r;
    end
    if (ctl.ld_out) begin
      pwm_r    <= pwm_nxt;
      out_st_r <= quot_st_r;
    end
  end

  assign pwm_compare = pwm_r;
  assign st_out      = out_st_r;

endmodule

`default_nettype wire

FILE: rtl/servo_slew_position_controller.sv
// top level of the servo slew position controller
`timescale 1ns / 1ps
`default_nettype none

// Servo slew position controller. Each input beat carries a command in
// in_tuser (tick, direct angle, goal angle) and a signed angle in in_tdata;
// each beat gives exactly one result beat with the pwm compare value, the
// current and goal angles and the stepping flag after that command. The
// block takes one beat per clock cycle unless output back-pressure fills
// the pipeline, and each result passes five registers: input register,
// state update, angle-times-span multiply, divide-by-range by reciprocal
// multiply, output register. The one-cycle rate comes from the state
// update, which reads and rewrites the servo state so the next command
// sees it at once. Every stage is elastic, so input beats keep coming while
// a result waits, until the whole pipeline is full. Configuration is written
// through the cfg_ port, which is always ready; the user must write it only
// while no beat is in flight, and the block itself does not enforce this.

module servo_slew_position_controller #(
  parameter int unsigned TICKS_PER_STEP = ssp_pkg::TICKS_PER_STEP_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ssp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [10:0] angle (signed)
  input  wire logic [ssp_pkg::IN_TUSER_W-1:0]     in_tuser,   // [1:0] op
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] pwm_compare, [24:16] current_angle, [33:25] target_angle, [34] stepping
  output logic [ssp_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ssp_pkg::cfg_t                            cfg_r;
  ssp_pkg::servo_st_t                       st_nxt;
  ssp_pkg::servo_st_t                       st_out;
  ssp_pkg::pipe_ctl_t                       ctl;
  logic [ssp_pkg::PWM_W-1:0]                pwm_compare;

  // input register
  ssp_pkg::op_t                             op_r;
  logic signed [ssp_pkg::IN_ANGLE_W-1:0]    angle_r;

  // valid bit per stage
  logic v_in_r, v_snap_r, v_prod_r, v_quot_r, v_out_r;
  logic rdy_in, rdy_snap, rdy_prod, rdy_quot, rdy_out;

  // a stage takes a new beat when it is empty or its beat moves on
  always_comb begin
    rdy_out  = !v_out_r  || out_tready;
    rdy_quot = !v_quot_r || rdy_out;
    rdy_prod = !v_prod_r || rdy_quot;
    rdy_snap = !v_snap_r || rdy_prod;
    rdy_in   = !v_in_r   || rdy_snap;
    ctl.ld_snap = rdy_snap;
    ctl.ld_prod = rdy_prod;
    ctl.ld_quot = rdy_quot;
    ctl.ld_out  = rdy_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r   <= 1'b0;
      v_snap_r <= 1'b0;
      v_prod_r <= 1'b0;
      v_quot_r <= 1'b0;
      v_out_r  <= 1'b0;
    end else begin
      if (rdy_in)   v_in_r   <= in_tvalid;
      if (rdy_snap) v_snap_r <= v_in_r;
      if (rdy_prod) v_prod_r <= v_snap_r;
      if (rdy_quot) v_quot_r <= v_prod_r;
      if (rdy_out)  v_out_r  <= v_quot_r;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (rdy_in) begin
      op_r    <= ssp_pkg::op_t'(in_tuser);
      angle_r <= $signed(in_tdata[ssp_pkg::IN_ANGLE_W-1:0]);
    end
  end

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_low       <= 16'd500;
      cfg_r.pwm_high      <= 16'd2500;
      cfg_r.angle_floor   <= 9'd0;
      cfg_r.angle_ceiling <= 9'd180;
      cfg_r.full_turn     <= 1'b0;
      cfg_r.step_size     <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (ssp_pkg::cfg_idx_t'(cfg_index))
        ssp_pkg::REG_PWM_LOW:       cfg_r.pwm_low       <= cfg_data;
        ssp_pkg::REG_PWM_HIGH:      cfg_r.pwm_high      <= cfg_data;
        ssp_pkg::REG_ANGLE_FLOOR:   cfg_r.angle_floor   <= cfg_data[ssp_pkg::ANGLE_W-1:0];
        ssp_pkg::REG_ANGLE_CEILING: cfg_r.angle_ceiling <= cfg_data[ssp_pkg::ANGLE_W-1:0];
        ssp_pkg::REG_FULL_TURN:     cfg_r.full_turn     <= cfg_data[0];
        ssp_pkg::REG_STEP_SIZE:     cfg_r.step_size     <= cfg_data[ssp_pkg::ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // state changes only when the input beat moves into the snapshot stage
  ssp_state #(
    .TICKS_PER_STEP (TICKS_PER_STEP)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (v_in_r && rdy_snap),
    .op     (op_r),
    .angle  (angle_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt)
  );

  ssp_pwm u_pwm (
    .clk         (clk),
    .ctl         (ctl),
    .st_nxt      (st_nxt),
    .cfg         (cfg_r),
    .pwm_compare (pwm_compare),
    .st_out      (st_out)
  );

  assign in_tready  = rdy_in;
  assign out_tvalid = v_out_r;
  assign cfg_ready  = 1'b1;
  assign out_tdata  = {5'b0, st_out.step, st_out.goal, st_out.pos, pwm_compare};

endmodule

`default_nettype wire

FILE: rtl/ssp_chk.sv
// port-level checker for the servo slew position controller, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "servo_slew_position_controller_defines.svh"

module ssp_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ssp_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // a stalled result beat keeps its data
  `SSP_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "result beat changed while stalled")

  // angles never leave the full-turn range
  `SSP_ASSERT(a_angle_range, out_tvalid |-> (out_tdata[24:16] <= 9'd360 && out_tdata[33:25] <= 9'd360), "angle out of range")

  // reset empties the pipeline
  `SSP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result beat right after reset")

  // an empty pipeline takes input at once
  `SSP_ASSERT_RST(a_rst_ready, !rst_n |=> in_tready, "input not ready right after reset")

endmodule

bind servo_slew_position_controller ssp_chk u_ssp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
